### rtl/dtjq_pkg.sv
// Shared types and constants for the due-time job queue.
// Used by dtjq_mem and due_time_job_queue_unit; depends on nothing.
`default_nettype none

package dtjq_pkg;

  // Request kinds carried on the input tuser.
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_POLL   = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LOOKAHEAD = 2'd0;
  localparam logic [1:0] CFG_SLEEP_CAP = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [7:0]  LOOKAHEAD_RST = 8'd5;
  localparam logic [15:0] SLEEP_CAP_RST = 16'd60;

  // Most jobs one poll may pop.
  localparam int unsigned MAX_RESULTS = 32;

  // Field widths.
  localparam int unsigned ID_W   = 16;
  localparam int unsigned TIME_W = 32;

  // One stored memory word: due time above job id.
  typedef struct packed {
    logic [TIME_W-1:0] due_time;
    logic [ID_W-1:0]   job_id;
  } entry_t;

  // One result word.
  typedef struct packed {
    logic        job_valid;
    logic [15:0] job_out;
    logic [15:0] sleep_time;
    logic        wake;
    logic [1:0]  status;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

### rtl/due_time_job_queue_unit.sv
// Top level of the due-time job queue: sequencer around a circular entry store.
// Depends on dtjq_pkg and dtjq_mem.
//
// Usage: requests enter on the s_axis stream (tuser = request kind), results
// leave on the m_axis stream, tlast marking the final word of a request.
// Configuration (lookahead, sleep cap) is written on the cfg channel, which
// is ready only while the sequencer is idle and no request is offered.
// The queue is a ring in one memory with a registered read; every memory
// step is a read state followed by an evaluate-and-write-back state.
// Insert walks back from the tail, moving each entry with a later due time
// back one slot, then writes the new entry into the free slot. Remove
// searches from the head for the first matching id, then moves each later
// entry forward one slot, or answers not found when no id matches. Poll
// pops due entries from the head, holding the last popped id back until an
// entry that is not yet due, an empty queue or the pop limit ends the walk;
// a poll that finds nothing due answers with a sleep time.
// A full insert, an empty remove or an empty poll answers with no memory step.
// The block takes one request at a time; s_axis_tready is high only while
// the sequencer is idle, so the next request can be taken in the cycle after
// the final word is loaded. A stalled receiver holds the result register, and
// the sequencer waits for it before it retires the next popped entry.
// Reset empties the queue at once (no clearing pass) and restores the
// configuration defaults; stored words are never read before written.
`default_nettype none

module due_time_job_queue_unit #(
  parameter int unsigned JOBS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Request stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [79:0] s_axis_tdata,   // job_id[15:0], due_time[47:16], now[79:48]
  input  wire logic [1:0]  s_axis_tuser,   // req_type[1:0]
  // Result stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // job_out[15:0], sleep_time[31:16], wake[32],
                                           // status[34:33], zero[39:35]
  output logic             m_axis_tuser,   // job_valid
  output logic             m_axis_tlast,
  // Configuration writes.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int unsigned IW = (JOBS > 1) ? $clog2(JOBS) : 1;
  localparam int unsigned CW = $clog2(JOBS + 1);
  localparam int unsigned NW = $clog2(dtjq_pkg::MAX_RESULTS + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(JOBS);
  localparam logic [NW-1:0] MAX_N    = NW'(dtjq_pkg::MAX_RESULTS);

  // Sequencer states.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EMIT   = 4'd1;
  localparam logic [3:0] S_INS_RD = 4'd2;
  localparam logic [3:0] S_INS_EV = 4'd3;
  localparam logic [3:0] S_PUT    = 4'd4;
  localparam logic [3:0] S_REM_RD = 4'd5;
  localparam logic [3:0] S_REM_EV = 4'd6;
  localparam logic [3:0] S_SH_RD  = 4'd7;
  localparam logic [3:0] S_SH_EV  = 4'd8;
  localparam logic [3:0] S_PL_RD  = 4'd9;
  localparam logic [3:0] S_PL_EV  = 4'd10;
  localparam logic [3:0] S_PL_FIN = 4'd11;

  // Ring position of a logical slot.
  function automatic logic [IW-1:0] phys(input logic [IW-1:0] head, input logic [IW-1:0] k);
    logic [IW:0] sum;
    sum = {1'b0, head} + {1'b0, k};
    if (sum >= (IW+1)'(JOBS)) begin
      sum = sum - (IW+1)'(JOBS);
    end
    return sum[IW-1:0];
  endfunction

  logic [3:0]        state_q, state_d;
  logic [IW-1:0]     head_q, head_d;
  logic [CW-1:0]     count_q, count_d;
  logic [IW-1:0]     k_q, k_d;
  logic [NW-1:0]     n_q, n_d;
  logic              pend_v_q, pend_v_d;
  logic [15:0]       pend_id_q, pend_id_d;
  logic [15:0]       id_q, id_d;
  logic [31:0]       due_q, due_d;
  logic [31:0]       now_q, now_d;
  logic [7:0]        lookahead_q;
  logic [15:0]       sleep_cap_q;
  dtjq_pkg::res_t    res_q, res_d;
  dtjq_pkg::res_t    out_q, out_d;
  logic              out_v_q, out_v_d;

  logic              ld;
  dtjq_pkg::res_t    ld_res;
  logic              out_free;
  logic              we, re;
  logic [IW-1:0]     waddr, raddr;
  dtjq_pkg::entry_t  wdata, rdata;
  logic [32:0]       limit;
  logic              is_due;
  logic [31:0]       gap;
  logic [15:0]       sleep_v;
  logic [IW-1:0]     head_inc;
  logic [CW-1:0]     k_ext;

  dtjq_mem #(
    .DEPTH (JOBS),
    .AW    (IW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Helpers on the word just read.
  assign limit    = {1'b0, now_q} + 33'(lookahead_q);
  assign is_due   = ({1'b0, rdata.due_time} <= limit);
  assign gap      = rdata.due_time - now_q;
  assign sleep_v  = (gap < {16'd0, sleep_cap_q}) ? gap[15:0] : sleep_cap_q;
  assign head_inc = (head_q == IW'(JOBS - 1)) ? '0 : head_q + 1'b1;
  assign k_ext    = CW'(k_q);
  assign out_free = !out_v_q || m_axis_tready;

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    count_d   = count_q;
    k_d       = k_q;
    n_d       = n_q;
    pend_v_d  = pend_v_q;
    pend_id_d = pend_id_q;
    id_d      = id_q;
    due_d     = due_q;
    now_d     = now_q;
    res_d     = res_q;
    ld        = 1'b0;
    ld_res    = '0;
    we        = 1'b0;
    waddr     = '0;
    wdata     = rdata;
    re        = 1'b0;
    raddr     = '0;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          id_d  = s_axis_tdata[15:0];
          due_d = s_axis_tdata[47:16];
          now_d = s_axis_tdata[79:48];
          res_d = '0;
          res_d.last = 1'b1;
          k_d = '0;
          n_d = '0;
          case (s_axis_tuser)
            dtjq_pkg::REQ_INSERT: begin
              if (count_q == FULL_CNT) begin
                res_d.status = dtjq_pkg::ST_FULL;
                state_d = S_EMIT;
              end else if (count_q == '0) begin
                state_d = S_PUT;
              end else begin
                k_d = IW'(count_q - 1'b1);
                state_d = S_INS_RD;
              end
            end
            dtjq_pkg::REQ_REMOVE: begin
              if (count_q == '0) begin
                res_d.status = dtjq_pkg::ST_NOT_FOUND;
                state_d = S_EMIT;
              end else begin
                state_d = S_REM_RD;
              end
            end
            dtjq_pkg::REQ_POLL: begin
              if (count_q == '0) begin
                res_d.sleep_time = sleep_cap_q;
                state_d = S_EMIT;
              end else begin
                state_d = S_PL_RD;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_EMIT: begin
        if (out_free) begin
          ld = 1'b1;
          ld_res = res_q;
          state_d = S_IDLE;
        end
      end

      // Insert: walk back from the tail, moving later entries up one slot.
      S_INS_RD: begin
        re = 1'b1;
        raddr = phys(head_q, k_q);
        state_d = S_INS_EV;
      end

      S_INS_EV: begin
        if (rdata.due_time > due_q) begin
          we = 1'b1;
          waddr = phys(head_q, k_q + 1'b1);
          if (k_q == '0) begin
            state_d = S_PUT;
          end else begin
            k_d = k_q - 1'b1;
            state_d = S_INS_RD;
          end
        end else begin
          k_d = k_q + 1'b1;
          state_d = S_PUT;
        end
      end

      S_PUT: begin
        we = 1'b1;
        waddr = phys(head_q, k_q);
        wdata.due_time = due_q;
        wdata.job_id = id_q;
        count_d = count_q + 1'b1;
        res_d.wake = (k_q == '0);
        state_d = S_EMIT;
      end

      // Remove: search from the head for the first matching id.
      S_REM_RD: begin
        re = 1'b1;
        raddr = phys(head_q, k_q);
        state_d = S_REM_EV;
      end

      S_REM_EV: begin
        if (rdata.job_id == id_q) begin
          if (k_ext + 1'b1 == count_q) begin
            count_d = count_q - 1'b1;
            state_d = S_EMIT;
          end else begin
            state_d = S_SH_RD;
          end
        end else if (k_ext + 1'b1 == count_q) begin
          res_d.status = dtjq_pkg::ST_NOT_FOUND;
          state_d = S_EMIT;
        end else begin
          k_d = k_q + 1'b1;
          state_d = S_REM_RD;
        end
      end

      // Close the hole: move each later entry down one slot.
      S_SH_RD: begin
        re = 1'b1;
        raddr = phys(head_q, k_q + 1'b1);
        state_d = S_SH_EV;
      end

      S_SH_EV: begin
        we = 1'b1;
        waddr = phys(head_q, k_q);
        k_d = k_q + 1'b1;
        if (k_ext + 2'd2 == count_q) begin
          count_d = count_q - 1'b1;
          state_d = S_EMIT;
        end else begin
          state_d = S_SH_RD;
        end
      end

      // Poll: pop due entries from the head; one popped id is held back
      // until the next entry shows whether it is the final word.
      S_PL_RD: begin
        re = 1'b1;
        raddr = head_q;
        state_d = S_PL_EV;
      end

      S_PL_EV: begin
        if (is_due) begin
          if (!pend_v_q || out_free) begin
            if (pend_v_q) begin
              ld = 1'b1;
              ld_res.job_valid = 1'b1;
              ld_res.job_out = pend_id_q;
            end
            pend_v_d = 1'b1;
            pend_id_d = rdata.job_id;
            head_d = head_inc;
            count_d = count_q - 1'b1;
            n_d = n_q + 1'b1;
            if (count_q == CW'(1) || n_q + 1'b1 == MAX_N) begin
              state_d = S_PL_FIN;
            end else begin
              state_d = S_PL_RD;
            end
          end
        end else if (pend_v_q) begin
          state_d = S_PL_FIN;
        end else if (out_free) begin
          ld = 1'b1;
          ld_res.sleep_time = sleep_v;
          ld_res.last = 1'b1;
          state_d = S_IDLE;
        end
      end

      S_PL_FIN: begin
        if (out_free) begin
          ld = 1'b1;
          ld_res.job_valid = 1'b1;
          ld_res.job_out = pend_id_q;
          ld_res.last = 1'b1;
          pend_v_d = 1'b0;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result register.
  assign out_v_d = ld || (out_v_q && !m_axis_tready);
  assign out_d   = ld ? ld_res : out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      pend_v_q    <= 1'b0;
      out_v_q     <= 1'b0;
      lookahead_q <= dtjq_pkg::LOOKAHEAD_RST;
      sleep_cap_q <= dtjq_pkg::SLEEP_CAP_RST;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      count_q  <= count_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
      if (cfg_valid_i && cfg_ready_o && cfg_index_i == dtjq_pkg::CFG_LOOKAHEAD) begin
        lookahead_q <= cfg_data_i[7:0];
      end
      if (cfg_valid_i && cfg_ready_o && cfg_index_i == dtjq_pkg::CFG_SLEEP_CAP) begin
        sleep_cap_q <= cfg_data_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    k_q       <= k_d;
    n_q       <= n_d;
    pend_id_q <= pend_id_d;
    id_q      <= id_d;
    due_q     <= due_d;
    now_q     <= now_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  // Configuration only lands between requests; an offered request goes first.
  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = (state_q == S_IDLE) && !s_axis_tvalid;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = out_q.job_valid;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {5'd0, out_q.status, out_q.wake, out_q.sleep_time, out_q.job_out};

  // The fill count never passes the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= FULL_CNT)
    else $error("entry count above capacity");

  // A full status only comes from an insert that met a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && res_q.status == dtjq_pkg::ST_FULL) |-> count_q == FULL_CNT)
    else $error("full status with room left");

  // A held-back popped id exists only while a poll is running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_v_q |-> (state_q == S_PL_RD || state_q == S_PL_EV || state_q == S_PL_FIN))
    else $error("pending pop outside a poll");

endmodule

`default_nettype wire

### rtl/dtjq_mem.sv
// Entry store of the job queue: one write port, one read port, registered read.
// Depends on dtjq_pkg for the entry word type.
`default_nettype none

module dtjq_mem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire dtjq_pkg::entry_t wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output dtjq_pkg::entry_t      rdata_o
);

  dtjq_pkg::entry_t mem [DEPTH];
  dtjq_pkg::entry_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
